/* rtl/tlt_pkg.sv */
// ----------------------------------------------------------------------------
// Tensor layout transposer package
// Shared widths, register indexes, reset values and the shape bundle.
// ----------------------------------------------------------------------------
package tlt_pkg;

   // Width of one tensor dimension register.
   localparam int DIM_W   = 7;
   // Width of height*width and of channels*height*width.
   localparam int HW_W    = 2 * DIM_W;
   localparam int TOTAL_W = 3 * DIM_W;
   // Width of one element word.
   localparam int WORD_W  = 32;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH     = 2'd3;

   // Register reset values.
   localparam logic             RST_DIRECTION = 1'b0;
   localparam logic [DIM_W-1:0] RST_CHANNELS  = 7'd3;
   localparam logic [DIM_W-1:0] RST_HEIGHT    = 7'd8;
   localparam logic [DIM_W-1:0] RST_WIDTH     = 7'd8;

   // Direction codes.
   localparam logic DIR_CHW_TO_HWC = 1'b0;
   localparam logic DIR_HWC_TO_CHW = 1'b1;

   // Request function codes.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   // Shape seen by the read address sequencer.
   typedef struct packed {
      logic             direction;
      logic [DIM_W-1:0] channels;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] width;
      logic [HW_W-1:0]  plane;     // height * width
   } shape_type;

endpackage

/* rtl/tlt_if.sv */
// ----------------------------------------------------------------------------
// Tensor layout transposer channels
// Valid/ready word channels for requests and responses.
// ----------------------------------------------------------------------------
interface tlt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [tlt_pkg::WORD_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface tlt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tlt_pkg::WORD_W-1:0] data_word;
   logic                      last;

   modport source (output valid, output data_word, output last, input ready);
   modport sink   (input valid, input data_word, input last, output ready);
endinterface

/* rtl/tlt_ram.sv */
// ----------------------------------------------------------------------------
// Tensor layout transposer RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tlt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tlt_seq.sv */
// ----------------------------------------------------------------------------
// Tensor layout transposer read sequencer
// Walks the target order and keeps the source address by increments.
// ----------------------------------------------------------------------------
module tlt_seq #(
   parameter int ADDR_W = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic               step,
   input  tlt_pkg::shape_type shape,
   output logic [ADDR_W-1:0]  rd_addr,
   output logic               last
);

   localparam int SUM_W = (ADDR_W > tlt_pkg::HW_W) ? ADDR_W + 1 : tlt_pkg::HW_W + 1;

   logic [tlt_pkg::DIM_W-1:0] row_ff, row_in;
   logic [tlt_pkg::DIM_W-1:0] col_ff, col_in;
   logic [tlt_pkg::DIM_W-1:0] chan_ff, chan_in;
   logic [ADDR_W-1:0]         pix_ff, pix_in;   // row * width + col
   logic [ADDR_W-1:0]         addr_ff, addr_in;

   logic                      row_wrap, col_wrap, chan_wrap;
   logic [SUM_W-1:0]          addr_plane;
   logic [SUM_W-1:0]          addr_chan;
   logic [ADDR_W-1:0]         pix_next;
   logic [tlt_pkg::DIM_W-1:0] chan_next;

   assign row_wrap  = (row_ff  == shape.height   - 1'b1);
   assign col_wrap  = (col_ff  == shape.width    - 1'b1);
   assign chan_wrap = (chan_ff == shape.channels - 1'b1);
   assign last      = row_wrap && col_wrap && chan_wrap;

   assign addr_plane = SUM_W'(addr_ff) + SUM_W'(shape.plane);
   assign addr_chan  = SUM_W'(addr_ff) + SUM_W'(shape.channels);
   assign pix_next   = last ? '0 : pix_ff + 1'b1;
   assign chan_next  = chan_wrap ? '0 : chan_ff + 1'b1;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      chan_in = chan_ff;
      pix_in  = pix_ff;
      addr_in = addr_ff;
      if (restart) begin
         row_in  = '0;
         col_in  = '0;
         chan_in = '0;
         pix_in  = '0;
         addr_in = '0;
      end else if (step) begin
         if (shape.direction == tlt_pkg::DIR_CHW_TO_HWC) begin
            // Channel runs fastest; one plane apart in the source.
            if (!chan_wrap) begin
               chan_in = chan_ff + 1'b1;
               addr_in = addr_plane[ADDR_W-1:0];
            end else begin
               chan_in = '0;
               pix_in  = pix_next;
               addr_in = pix_next;
               if (col_wrap) begin
                  col_in = '0;
                  row_in = row_wrap ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end else begin
            // Column runs fastest; one pixel (channels words) apart.
            if (!col_wrap) begin
               col_in  = col_ff + 1'b1;
               addr_in = addr_chan[ADDR_W-1:0];
            end else if (!row_wrap) begin
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               addr_in = addr_chan[ADDR_W-1:0];
            end else begin
               col_in  = '0;
               row_in  = '0;
               chan_in = chan_next;
               addr_in = ADDR_W'(chan_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         chan_ff <= '0;
         pix_ff  <= '0;
         addr_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         chan_ff <= chan_in;
         pix_ff  <= pix_in;
         addr_ff <= addr_in;
      end
   end

   assign rd_addr = addr_ff;

endmodule

/* rtl/tensor_layout_transposer.sv */
// ----------------------------------------------------------------------------
// Tensor layout transposer
// Reorders one tensor between CHW and HWC layouts through an element RAM.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on req_if. A load word (func 0) stores value as the next
// element in source order; loads past channels*height*width are dropped.
// A fetch word (func 1) is honored only once the whole tensor is loaded and
// returns the next element in target order on rsp_if, with last set on the
// final element, after which the order wraps to the start. Other fetches
// produce no response.
// Throughput is one word per cycle while req_if.ready is high: the load counter
// and the incremental read address counter each advance by one step a cycle,
// and the element RAM has one write and one read port. A fetch response passes
// through the registered RAM read and then the response register.
// A csr_we write selects the register by csr_index, restarts the load and
// fetch positions and holds req_if.ready low while the shape products are
// rebuilt. Reset restores the default shape and does the same; the RAM
// contents are not cleared.
// When rsp_if stalls, the RAM output stage and the response register hold up
// to two results, and req_if.ready drops only when both are full.
// ----------------------------------------------------------------------------
module tensor_layout_transposer #(
   parameter int CAPACITY = 4096,
   parameter int MAX_DIM  = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   tlt_req_if.sink                         req_if,
   tlt_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [tlt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tlt_pkg::DIM_W-1:0]       csr_wdata
);

   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // Configuration registers.
   logic                      direction_ff, direction_in;
   logic [tlt_pkg::DIM_W-1:0] channels_ff, channels_in;
   logic [tlt_pkg::DIM_W-1:0] height_ff, height_in;
   logic [tlt_pkg::DIM_W-1:0] width_ff, width_in;

   // Shape products, rebuilt through plane_ff and then total_ff after any change.
   logic [tlt_pkg::HW_W-1:0]    plane_ff, plane_in;
   logic [tlt_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [1:0]                  settle_ff, settle_in;
   logic                        shape_ok;

   // Load side.
   logic [COUNT_W-1:0] load_count_ff, load_count_in;
   logic               load_fire;
   logic               fetch_fire;
   logic               req_fire;
   logic               loaded;

   // Read pipeline: RAM output stage, then response register.
   logic                       s1_vld_ff, s1_vld_in;
   logic                       s1_last_ff;
   logic                       s1_move;
   logic                       out_vld_ff, out_vld_in;
   logic [tlt_pkg::WORD_W-1:0] out_data_ff;
   logic                       out_last_ff;

   logic [tlt_pkg::WORD_W-1:0] ram_rd_data;
   logic [ADDR_W-1:0]          seq_addr;
   logic                       seq_last;
   tlt_pkg::shape_type         shape;

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   always_comb begin
      direction_in = direction_ff;
      channels_in  = channels_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      if (csr_we) begin
         unique case (csr_index)
            tlt_pkg::REG_DIRECTION: direction_in = csr_wdata[0];
            tlt_pkg::REG_CHANNELS:  channels_in  = csr_wdata;
            tlt_pkg::REG_HEIGHT:    height_in    = csr_wdata;
            tlt_pkg::REG_WIDTH:     width_in     = csr_wdata;
         endcase
      end
   end

   assign plane_in  = tlt_pkg::HW_W'(height_ff) * tlt_pkg::HW_W'(width_ff);
   assign total_in  = tlt_pkg::TOTAL_W'(plane_ff) * tlt_pkg::TOTAL_W'(channels_ff);
   assign settle_in = csr_we ? 2'd2 : ((settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0);

   // A shape is usable when every dimension is in range and the tensor fits.
   assign shape_ok = (channels_ff != '0) && (height_ff != '0) && (width_ff != '0)
                  && (32'(channels_ff) <= 32'(MAX_DIM))
                  && (32'(height_ff) <= 32'(MAX_DIM))
                  && (32'(width_ff) <= 32'(MAX_DIM))
                  && (32'(total_ff) <= 32'(CAPACITY));

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= tlt_pkg::RST_DIRECTION;
         channels_ff  <= tlt_pkg::RST_CHANNELS;
         height_ff    <= tlt_pkg::RST_HEIGHT;
         width_ff     <= tlt_pkg::RST_WIDTH;
         settle_ff    <= 2'd2;
      end else begin
         direction_ff <= direction_in;
         channels_ff  <= channels_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         settle_ff    <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      total_ff <= total_in;
   end

   // ---------------------------------------------------------------------
   // Request handling
   // ---------------------------------------------------------------------
   assign s1_move      = s1_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready = (settle_ff == 2'd0) && (!s1_vld_ff || s1_move);
   assign req_fire     = req_if.valid && req_if.ready;

   assign loaded     = shape_ok && (32'(load_count_ff) == 32'(total_ff));
   assign load_fire  = req_fire && (req_if.func == tlt_pkg::FUNC_LOAD) && shape_ok
                    && (32'(load_count_ff) < 32'(total_ff));
   assign fetch_fire = req_fire && (req_if.func == tlt_pkg::FUNC_FETCH) && loaded;

   always_comb begin
      load_count_in = load_count_ff;
      if (csr_we) begin
         load_count_in = '0;
      end else if (load_fire) begin
         load_count_in = load_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Element store and read order
   // ---------------------------------------------------------------------
   assign shape.direction = direction_ff;
   assign shape.channels  = channels_ff;
   assign shape.height    = height_ff;
   assign shape.width     = width_ff;
   assign shape.plane     = plane_ff;

   tlt_seq #(
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_we),
      .step    (fetch_fire),
      .shape   (shape),
      .rd_addr (seq_addr),
      .last    (seq_last)
   );

   tlt_ram #(
      .WIDTH (tlt_pkg::WORD_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data (req_if.value),
      .rd_en   (fetch_fire),
      .rd_addr (seq_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Response pipeline
   // ---------------------------------------------------------------------
   assign s1_vld_in  = fetch_fire ? 1'b1 : (s1_move ? 1'b0 : s1_vld_ff);
   assign out_vld_in = s1_move ? 1'b1 : (rsp_if.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_fire) begin
         s1_last_ff <= seq_last;
      end
      if (s1_move) begin
         out_data_ff <= ram_rd_data;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_if.valid     = out_vld_ff;
   assign rsp_if.data_word = out_data_ff;
   assign rsp_if.last      = out_last_ff;

`ifndef NO_ASSERTIONS
   // An accepted fetch always lands in the RAM output stage.
   a_fetch_to_s1: assert property (@(posedge clock) disable iff (reset)
      fetch_fire |=> s1_vld_ff)
      else $error("fetch was accepted but no read result is staged");

   // A staged result is never dropped while the response register is stalled.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && out_vld_ff && !rsp_if.ready |=> s1_vld_ff && out_vld_ff)
      else $error("staged result lost during a response stall");

   // After a register write no request is taken while the shape settles.
   a_settle: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_if.ready)
      else $error("request accepted before the shape products settled");

   // The load counter never passes the tensor size.
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == 2'd0) && shape_ok |-> 32'(load_count_ff) <= 32'(total_ff))
      else $error("load counter ran past the tensor size");
`endif

endmodule

/* tb/sv/tensor_layout_transposer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor layout transposer testbench
// Loads tensors word by word in source order, fetches them back in target
// order and checks every response against a predictor kept in step with
// each accepted request word. Covers both directions, reset and edge
// shapes, dead shapes, restarts, the largest dimension, long backpressure
// and randomized shapes and traffic.
// ----------------------------------------------------------------------------
module tensor_layout_transposer_tb;

   localparam int STORE_DEPTH    = 4096;
   localparam int DIM_LIMIT      = 64;
   // Cycles to let pass after the last response before touching registers.
   // A response leaves through the RAM read register and the response register, so this is enough margin.
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_ITEMS   = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [3:0] ALL_REGS   = 4'b1111;
   localparam logic [3:0] WIDTH_ONLY = 4'b0001 << tlt_pkg::REG_WIDTH;

   // One response word as the block should return it.
   typedef struct packed {
      logic [tlt_pkg::WORD_W-1:0] data_word;
      logic                       last;
   } fetched_word_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [tlt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tlt_pkg::DIM_W-1:0]     csr_wdata;

   tlt_req_if req_bus ();
   tlt_rsp_if rsp_bus ();

   tensor_layout_transposer #(
      .CAPACITY (STORE_DEPTH),
      .MAX_DIM  (DIM_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block: shape registers, stored elements, load count
   // and the target-order read position.
   logic                       mirror_dir;
   int unsigned                mirror_chans;
   int unsigned                mirror_rows;
   int unsigned                mirror_cols;
   int unsigned                loaded_count;
   int unsigned                pos_row;
   int unsigned                pos_col;
   int unsigned                pos_chan;
   logic [tlt_pkg::WORD_W-1:0] tensor_mirror [STORE_DEPTH];

   // Responses still owed by the block, oldest first.
   fetched_word_type expected_fetches [$];

   // When set, both sides run without idle cycles.
   bit no_idle;
   // A nonzero value asks the response side to hold ready low that long.
   int rsp_hold_request;

   int error_count;
   int words_sent;
   int effective_words;
   int checked_words;
   int csr_writes;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Element count of the current shape, zero when the shape is unusable:
   // a zero dimension, a dimension over the limit, or more than the store.
   function automatic int unsigned shape_elems();
      if (mirror_chans == 0 || mirror_rows == 0 || mirror_cols == 0) return 0;
      if (mirror_chans > DIM_LIMIT || mirror_rows > DIM_LIMIT || mirror_cols > DIM_LIMIT)
         return 0;
      if (mirror_chans * mirror_rows * mirror_cols > STORE_DEPTH) return 0;
      return mirror_chans * mirror_rows * mirror_cols;
   endfunction

   // Applies one accepted request word to the shadow state. A load fills the
   // next source slot until the tensor is complete. A fetch on a complete
   // tensor queues the element at the current target position and steps the
   // position, wrapping after the final element. Returns 1 when the word had
   // an effect, 0 when the block ignores it.
   function automatic bit predict_transpose(input logic f,
                                            input logic [tlt_pkg::WORD_W-1:0] v);
      int unsigned      elems;
      int unsigned      src;
      fetched_word_type word;
      elems = shape_elems();
      if (f == tlt_pkg::FUNC_LOAD) begin
         if (elems == 0 || loaded_count >= elems) return 1'b0;
         tensor_mirror[loaded_count] = v;
         loaded_count++;
         return 1'b1;
      end
      if (elems == 0 || loaded_count != elems) return 1'b0;
      word.last = (pos_row == mirror_rows - 1) && (pos_col == mirror_cols - 1) &&
                  (pos_chan == mirror_chans - 1);
      if (mirror_dir == tlt_pkg::DIR_CHW_TO_HWC) begin
         // Planar source, channel runs fastest in the output.
         src = pos_chan * mirror_rows * mirror_cols + pos_row * mirror_cols + pos_col;
         pos_chan++;
         if (pos_chan == mirror_chans) begin
            pos_chan = 0;
            pos_col++;
            if (pos_col == mirror_cols) begin
               pos_col = 0;
               pos_row++;
               if (pos_row == mirror_rows) pos_row = 0;
            end
         end
      end else begin
         // Interleaved source, column runs fastest in the output.
         src = pos_row * mirror_cols * mirror_chans + pos_col * mirror_chans + pos_chan;
         pos_col++;
         if (pos_col == mirror_cols) begin
            pos_col = 0;
            pos_row++;
            if (pos_row == mirror_rows) begin
               pos_row = 0;
               pos_chan++;
               if (pos_chan == mirror_chans) pos_chan = 0;
            end
         end
      end
      word.data_word = tensor_mirror[src];
      expected_fetches.push_back(word);
      return 1'b1;
   endfunction

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 10);
   endfunction

   // Element words lean toward all zeros and all ones now and then.
   function automatic logic [tlt_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   // Offers one request word after a random gap and returns at the clock
   // edge that accepts it. Called at a rising edge. Handshakes are sampled
   // on the falling edge, where every signal has settled for the next edge.
   task automatic send_word(input logic f, input logic [tlt_pkg::WORD_W-1:0] v);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= f;
      req_bus.value <= v;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      words_sent++;
      if (predict_transpose(f, v)) effective_words++;
   endtask

   task automatic load_tensor(input int unsigned count);
      repeat (count) send_word(tlt_pkg::FUNC_LOAD, pick_value());
   endtask

   task automatic fetch_words(input int unsigned count);
      repeat (count) send_word(tlt_pkg::FUNC_FETCH, $urandom());
   endtask

   // Stops offering words, waits for every owed response and lets the block
   // settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_fetches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register; any write restarts loading and the read position.
   task automatic put_reg(input logic [tlt_pkg::CSR_IDX_W-1:0] idx,
                          input logic [tlt_pkg::DIM_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         tlt_pkg::REG_DIRECTION: mirror_dir   = data[0];
         tlt_pkg::REG_CHANNELS:  mirror_chans = data;
         tlt_pkg::REG_HEIGHT:    mirror_rows  = data;
         tlt_pkg::REG_WIDTH:     mirror_cols  = data;
         default: ;
      endcase
      loaded_count = 0;
      pos_row      = 0;
      pos_col      = 0;
      pos_chan     = 0;
      csr_writes++;
   endtask

   // Writes the registers selected by mask back to back, once the block is
   // idle. Unselected registers keep their values.
   task automatic write_regs(input logic [3:0] mask, input logic d,
                             input logic [tlt_pkg::DIM_W-1:0] c,
                             input logic [tlt_pkg::DIM_W-1:0] h,
                             input logic [tlt_pkg::DIM_W-1:0] w);
      wait_idle();
      if (mask[tlt_pkg::REG_DIRECTION])
         put_reg(tlt_pkg::REG_DIRECTION, tlt_pkg::DIM_W'(d));
      if (mask[tlt_pkg::REG_CHANNELS])  put_reg(tlt_pkg::REG_CHANNELS, c);
      if (mask[tlt_pkg::REG_HEIGHT])    put_reg(tlt_pkg::REG_HEIGHT, h);
      if (mask[tlt_pkg::REG_WIDTH])     put_reg(tlt_pkg::REG_WIDTH, w);
      csr_we <= 1'b0;
   endtask

   // A shape the block must refuse: the load is dropped and the fetch is
   // left without a response.
   task automatic probe_dead_shape(input logic [tlt_pkg::DIM_W-1:0] c,
                                   input logic [tlt_pkg::DIM_W-1:0] h,
                                   input logic [tlt_pkg::DIM_W-1:0] w);
      write_regs(ALL_REGS, tlt_pkg::DIR_CHW_TO_HWC, c, h, w);
      send_word(tlt_pkg::FUNC_LOAD, pick_value());
      fetch_words(1);
   endtask

   // The shape left by reset, read out once and wrapped by one more fetch.
   // The first fetch comes before any load and must be ignored.
   task automatic test_reset_shape();
      fetch_words(1);
      load_tensor(shape_elems());
      fetch_words(shape_elems() + 1);
   endtask

   task automatic test_special_cases();
      // A single element: every fetch is the final one, and a second load
      // finds the tensor full and is dropped.
      write_regs(ALL_REGS, tlt_pkg::DIR_CHW_TO_HWC, 7'd1, 7'd1, 7'd1);
      send_word(tlt_pkg::FUNC_LOAD, '0);
      send_word(tlt_pkg::FUNC_LOAD, '1);
      fetch_words(2);
      // A fetch in the middle of loading gives nothing and does not move
      // the read position.
      write_regs(ALL_REGS, tlt_pkg::DIR_HWC_TO_CHW, 7'd2, 7'd1, 7'd2);
      send_word(tlt_pkg::FUNC_LOAD, '1);
      fetch_words(1);
      send_word(tlt_pkg::FUNC_LOAD, 32'hA5A5_A5A5);
      send_word(tlt_pkg::FUNC_LOAD, 32'h5A5A_5A5A);
      send_word(tlt_pkg::FUNC_LOAD, '0);
      fetch_words(5);
      // Rewriting one register with its own value still restarts the load.
      write_regs(ALL_REGS, tlt_pkg::DIR_CHW_TO_HWC, 7'd1, 7'd1, 7'd2);
      send_word(tlt_pkg::FUNC_LOAD, 32'h0000_0001);
      write_regs(WIDTH_ONLY, tlt_pkg::DIR_CHW_TO_HWC, 7'd1, 7'd1, 7'd2);
      fetch_words(1);
      send_word(tlt_pkg::FUNC_LOAD, 32'h8000_0000);
      send_word(tlt_pkg::FUNC_LOAD, 32'h7FFF_FFFF);
      fetch_words(2);
      // Zero channels, height over the limit, width at its all-ones code,
      // and legal dimensions whose product overflows the store.
      probe_dead_shape(7'd0, 7'd1, 7'd1);
      probe_dead_shape(7'd1, 7'd65, 7'd1);
      probe_dead_shape(7'd1, 7'd1, 7'd127);
      probe_dead_shape(7'd64, 7'd64, 7'd2);
   endtask

   // Maximum width in a single row and channel, read out once and wrapped.
   task automatic test_largest_shapes();
      write_regs(ALL_REGS, tlt_pkg::DIR_CHW_TO_HWC, 7'd1, 7'd1, 7'd64);
      load_tensor(shape_elems());
      fetch_words(shape_elems() + 1);
   endtask

   task automatic test_backpressure();
      write_regs(ALL_REGS, tlt_pkg::DIR_HWC_TO_CHW, 7'd2, 7'd2, 7'd3);
      no_idle = 1'b1;
      load_tensor(shape_elems());
      // The response side goes quiet for a long stretch while fetches keep
      // coming, so the two result stages fill and the request side stalls.
      rsp_hold_request = 300;
      fetch_words(30);
      // Hold back until everything owed has drained, then run a burst at
      // full rate on both sides.
      wait_idle();
      fetch_words(24);
      no_idle = 1'b0;
   endtask

   // Random shapes and traffic. Most rounds load a full tensor with stray
   // early fetches and read it back one to two times with stray late
   // loads; some rounds break off part way or use a dead shape.
   task automatic test_random_tensors();
      int unsigned               base;
      int unsigned               elems;
      int unsigned               fetches;
      logic                      d;
      logic [tlt_pkg::DIM_W-1:0] c;
      logic [tlt_pkg::DIM_W-1:0] h;
      logic [tlt_pkg::DIM_W-1:0] w;
      logic [3:0]                mask;
      base = effective_words;
      while (effective_words - base < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         d = 1'($urandom_range(0, 1));
         c = tlt_pkg::DIM_W'($urandom_range(1, 4));
         h = tlt_pkg::DIM_W'($urandom_range(1, 4));
         w = tlt_pkg::DIM_W'($urandom_range(1, 5));
         case ($urandom_range(0, 11))
            0: begin
               c = tlt_pkg::DIM_W'(DIM_LIMIT);
               h = 7'd1;
               w = 7'd1;
            end
            1: begin
               h = tlt_pkg::DIM_W'(DIM_LIMIT);
               w = 7'd1;
               c = 7'd1;
            end
            2: begin
               w = tlt_pkg::DIM_W'(DIM_LIMIT);
               c = 7'd1;
               h = 7'd1;
            end
            3: begin
               case ($urandom_range(0, 2))
                  0: h = '0;
                  1: w = tlt_pkg::DIM_W'($urandom_range(DIM_LIMIT + 1, 127));
                  default: begin
                     c = tlt_pkg::DIM_W'(DIM_LIMIT);
                     h = tlt_pkg::DIM_W'(DIM_LIMIT);
                     w = tlt_pkg::DIM_W'($urandom_range(2, DIM_LIMIT));
                  end
               endcase
            end
            default: ;
         endcase
         mask = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : ALL_REGS;
         write_regs(mask, d, c, h, w);
         elems = shape_elems();
         if (elems == 0) begin
            repeat ($urandom_range(2, 4)) send_word(1'($urandom_range(0, 1)), pick_value());
         end else if ($urandom_range(0, 7) == 0) begin
            // Broken off: the next register write throws the partial load away.
            load_tensor($urandom_range(0, elems - 1));
            fetch_words(1);
         end else begin
            for (int i = 0; i < elems; i++) begin
               if ($urandom_range(0, 15) == 0) send_word(tlt_pkg::FUNC_FETCH, pick_value());
               send_word(tlt_pkg::FUNC_LOAD, pick_value());
            end
            fetches = elems + $urandom_range(0, elems);
            for (int i = 0; i < fetches; i++) begin
               if ($urandom_range(0, 11) == 0) send_word(tlt_pkg::FUNC_LOAD, pick_value());
               send_word(tlt_pkg::FUNC_FETCH, pick_value());
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // Response side: for each word it idles a random number of cycles (or
   // the requested hold), then raises ready until a word goes through.
   initial begin : rsp_pacer
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            gap = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            gap = draw_gap();
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_bus.valid && rsp_hold_request == 0) @(negedge clock);
         @(posedge clock);
      end
   end

   // Every response word that the next edge accepts is compared with the
   // oldest owed one.
   always @(negedge clock) begin : response_check
      fetched_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         checked_words++;
         if (expected_fetches.size() == 0) begin
            flag_error($sformatf("response with none owed: data_word %08h last %0b",
                                 rsp_bus.data_word, rsp_bus.last));
         end else begin
            want = expected_fetches.pop_front();
            if (rsp_bus.data_word !== want.data_word || rsp_bus.last !== want.last)
               flag_error($sformatf("response %0d: want data_word %08h last %0b, got %08h %0b",
                                    checked_words, want.data_word, want.last,
                                    rsp_bus.data_word, rsp_bus.last));
         end
      end
   end

   // Ends the run when nothing moves for too long.
   always @(negedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d responses owed",
                     stall_cycles, expected_fetches.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= tlt_pkg::REG_DIRECTION;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.func  <= tlt_pkg::FUNC_LOAD;
      req_bus.value <= '0;
      no_idle          = 1'b0;
      rsp_hold_request = 0;
      error_count      = 0;
      words_sent       = 0;
      effective_words  = 0;
      checked_words    = 0;
      csr_writes       = 0;
      stall_cycles     = 0;
      mirror_dir   = tlt_pkg::RST_DIRECTION;
      mirror_chans = tlt_pkg::RST_CHANNELS;
      mirror_rows  = tlt_pkg::RST_HEIGHT;
      mirror_cols  = tlt_pkg::RST_WIDTH;
      loaded_count = 0;
      pos_row      = 0;
      pos_col      = 0;
      pos_chan     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_shape();
      test_special_cases();
      test_largest_shapes();
      test_backpressure();
      test_random_tensors();

      wait_idle();
      $display("Sent %0d request words (%0d stored or answered), checked %0d responses,",
               words_sent, effective_words, checked_words);
      $display("over %0d register writes, both directions, dead and full-length shapes.",
               csr_writes);
      if (error_count == 0 && expected_fetches.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d responses missing", error_count,
                  expected_fetches.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* tensor_layout_transposer.f */
rtl/tlt_pkg.sv
rtl/tlt_if.sv
rtl/tlt_ram.sv
rtl/tlt_seq.sv
rtl/tensor_layout_transposer.sv
tb/sv/tensor_layout_transposer_tb.sv
